FILE: rtl/core/ddfp_pkg.sv
// Shared constants and types of the double delimiter frame parser.
`default_nettype none

package ddfp_pkg;

   localparam int DEFAULT_BUF_DEPTH = 32;

   localparam int DATA_W   = 8;
   localparam int INDEX_W  = 5;
   localparam int LENGTH_W = 6;
   localparam int PHASE_W  = 2;
   localparam int CODE_W   = 3;

   // Parse phases
   localparam logic [PHASE_W-1:0] PH_HUNT    = 2'd0;
   localparam logic [PHASE_W-1:0] PH_START   = 2'd1;
   localparam logic [PHASE_W-1:0] PH_PAYLOAD = 2'd2;
   localparam logic [PHASE_W-1:0] PH_END     = 2'd3;

   // Operations
   localparam logic OP_RECEIVE = 1'b0;
   localparam logic OP_READ    = 1'b1;

   // Register indexes
   localparam logic CSR_START_BYTE = 1'b0;
   localparam logic CSR_END_BYTE   = 1'b1;

   localparam logic [DATA_W-1:0] START_BYTE_RESET = 8'h61;
   localparam logic [DATA_W-1:0] END_BYTE_RESET   = 8'h62;

   // Command characters '1' .. '5'
   localparam logic [DATA_W-1:0] CHAR_CMD_FIRST = 8'h31;
   localparam logic [DATA_W-1:0] CHAR_CMD_LAST  = 8'h35;

   typedef struct packed {
      logic wr_en;
      logic clear;
   } buf_ctrl_type;

endpackage

`default_nettype wire

FILE: rtl/core/ddfp_req_if.sv
// Request channel: one received byte or one buffer read.
`default_nettype none

interface ddfp_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;
   logic [4:0] read_index;

   modport source (output valid, output op, output rx_byte, output read_index, input ready);
   modport sink   (input valid, input op, input rx_byte, input read_index, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ddfp_rsp_if.sv
// Response channel: parser status and read data for one request.
`default_nettype none

interface ddfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic [1:0] phase;
   logic       frame_done;
   logic       overflow;
   logic [5:0] frame_length;
   logic       command_valid;
   logic [2:0] command_code;

   modport source (output valid, output read_data, output phase, output frame_done,
                   output overflow, output frame_length, output command_valid,
                   output command_code, input ready);
   modport sink   (input valid, input read_data, input phase, input frame_done,
                   input overflow, input frame_length, input command_valid,
                   input command_code, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ddfp_buffer.sv
// Payload buffer: byte registers with per-entry valid bits and a one-cycle clear.
`default_nettype none

module ddfp_buffer #(
   parameter int BUF_DEPTH = ddfp_pkg::DEFAULT_BUF_DEPTH,
   parameter int IDX_W     = $clog2(BUF_DEPTH)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ddfp_pkg::buf_ctrl_type     ctrl,
   input  wire logic [IDX_W-1:0]           wr_addr,
   input  wire logic [ddfp_pkg::DATA_W-1:0] wr_data,
   input  wire logic [IDX_W-1:0]           rd_addr,
   output logic      [ddfp_pkg::DATA_W-1:0] rd_data,
   output logic      [ddfp_pkg::DATA_W-1:0] head_data
);
   import ddfp_pkg::*;

   logic [DATA_W-1:0]    data_ff [BUF_DEPTH];
   logic [BUF_DEPTH-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         valid_ff <= '0;
      end else if (ctrl.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         data_ff[wr_addr] <= wr_data;
      end
   end

   // An entry not written since the last clear reads as zero
   always_comb begin
      rd_data   = valid_ff[rd_addr] ? data_ff[rd_addr] : '0;
      head_data = valid_ff[0] ? data_ff[0] : '0;
   end

endmodule

`default_nettype wire

FILE: rtl/core/double_delimiter_frame_parser.sv
// Top level of the double delimiter frame parser.
//
// Finds frames that open with two start bytes and close with two end bytes, stores the
// payload (including the first byte of the closing pair) and reports length and a
// command code from payload byte 0 on completion. A read request returns a stored
// payload byte. Every request gives exactly one response. The block takes one request
// per clock cycle while the response is not stalled: a request is registered, evaluated
// against the parser state in one pass of logic and its response registered, so the
// parser state loop holds a single register. A request passes through the input register
// and then the response register; a stalled response holds the input register, so at
// most two requests are in flight. A byte that finds the buffer full drops the frame and
// clears the buffer in that same cycle.
// Write the start and end bytes only while no request is in flight.
`default_nettype none

module double_delimiter_frame_parser #(
   parameter int BUF_DEPTH = ddfp_pkg::DEFAULT_BUF_DEPTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   ddfp_req_if.sink                         req_chan,
   ddfp_rsp_if.source                       rsp_chan,
   input  wire logic                        csr_wr_en,
   input  wire logic                        csr_index,
   input  wire logic [ddfp_pkg::DATA_W-1:0] csr_wr_data
);
   import ddfp_pkg::*;

   localparam int IDX_W = $clog2(BUF_DEPTH);
   localparam int CNT_W = $clog2(BUF_DEPTH + 1);

   // Configuration
   logic [DATA_W-1:0] start_byte_ff;
   logic [DATA_W-1:0] end_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RESET;
         end_byte_ff   <= END_BYTE_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_START_BYTE) begin
            start_byte_ff <= csr_wr_data;
         end
         if (csr_index == CSR_END_BYTE) begin
            end_byte_ff <= csr_wr_data;
         end
      end
   end

   // Input register
   logic               s1_valid_ff;
   logic               s1_op_ff;
   logic [DATA_W-1:0]  s1_byte_ff;
   logic [INDEX_W-1:0] s1_index_ff;
   logic               advance;
   logic               req_ready;

   assign advance   = s1_valid_ff && (!rsp_chan.valid || rsp_chan.ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_chan.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_chan.valid) begin
         s1_op_ff    <= req_chan.op;
         s1_byte_ff  <= req_chan.rx_byte;
         s1_index_ff <= req_chan.read_index;
      end
   end

   // Parser state
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   last_len_ff, last_len_in;

   buf_ctrl_type       buf_ctrl;
   logic [IDX_W-1:0]   buf_rd_addr;
   logic [DATA_W-1:0]  buf_rd_data;
   logic [DATA_W-1:0]  buf_head;

   logic [IDX_W+INDEX_W-1:0] rd_index_ext;
   logic                     rd_in_range;
   logic                     buf_full;

   logic [DATA_W-1:0]  read_data_in;
   logic               done_in;
   logic               overflow_in;
   logic               cmd_valid_in;
   logic [CODE_W-1:0]  cmd_code_in;
   logic [DATA_W-1:0]  cmd_offset;
   logic [CNT_W+LENGTH_W-1:0] len_ext;

   assign rd_index_ext = {{IDX_W{1'b0}}, s1_index_ff};
   assign rd_in_range  = rd_index_ext < BUF_DEPTH;
   assign buf_rd_addr  = rd_index_ext[IDX_W-1:0];
   assign buf_full     = count_ff == CNT_W'(BUF_DEPTH);
   assign cmd_offset   = buf_head - CHAR_CMD_FIRST;

   ddfp_buffer #(
      .BUF_DEPTH (BUF_DEPTH),
      .IDX_W     (IDX_W)
   ) u_buffer (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (buf_ctrl),
      .wr_addr   (count_ff[IDX_W-1:0]),
      .wr_data   (s1_byte_ff),
      .rd_addr   (buf_rd_addr),
      .rd_data   (buf_rd_data),
      .head_data (buf_head)
   );

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      last_len_in   = last_len_ff;
      buf_ctrl      = '0;
      read_data_in  = '0;
      done_in       = 1'b0;
      overflow_in   = 1'b0;
      cmd_valid_in  = 1'b0;
      cmd_code_in   = '0;

      if (s1_op_ff == OP_READ) begin
         if (rd_in_range) begin
            read_data_in = buf_rd_data;
         end
      end else begin
         case (phase_ff)
            PH_HUNT: begin
               if (s1_byte_ff == start_byte_ff) begin
                  phase_in = PH_START;
               end
            end
            PH_START: begin
               if (s1_byte_ff == start_byte_ff) begin
                  phase_in = PH_PAYLOAD;
                  count_in = '0;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_PAYLOAD: begin
               if (buf_full) begin
                  // drop the frame
                  overflow_in    = 1'b1;
                  buf_ctrl.clear = 1'b1;
                  count_in       = '0;
                  phase_in       = PH_HUNT;
               end else begin
                  if (s1_byte_ff == end_byte_ff) begin
                     phase_in = PH_END;
                  end
                  buf_ctrl.wr_en = 1'b1;
                  count_in       = count_ff + 1'b1;
               end
            end
            PH_END: begin
               if (s1_byte_ff == end_byte_ff) begin
                  last_len_in = count_ff;
                  phase_in    = PH_HUNT;
                  count_in    = '0;
                  done_in     = 1'b1;
               end else if (buf_full) begin
                  overflow_in    = 1'b1;
                  buf_ctrl.clear = 1'b1;
                  count_in       = '0;
                  phase_in       = PH_HUNT;
               end else begin
                  // lone end byte was data: keep going
                  phase_in       = PH_PAYLOAD;
                  buf_ctrl.wr_en = 1'b1;
                  count_in       = count_ff + 1'b1;
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase

         if (done_in && (buf_head inside {[CHAR_CMD_FIRST:CHAR_CMD_LAST]})) begin
            cmd_valid_in = 1'b1;
            cmd_code_in  = cmd_offset[CODE_W-1:0];
         end
      end

      if (!advance) begin
         buf_ctrl = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         count_ff    <= '0;
         last_len_ff <= '0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         last_len_ff <= last_len_in;
      end
   end

   assign len_ext = {{LENGTH_W{1'b0}}, last_len_in};

   // Response register
   logic                rsp_valid_ff;
   logic [DATA_W-1:0]   rsp_read_data_ff;
   logic [PHASE_W-1:0]  rsp_phase_ff;
   logic                rsp_done_ff;
   logic                rsp_overflow_ff;
   logic [LENGTH_W-1:0] rsp_length_ff;
   logic                rsp_cmd_valid_ff;
   logic [CODE_W-1:0]   rsp_cmd_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_read_data_ff <= read_data_in;
         rsp_phase_ff     <= phase_in;
         rsp_done_ff      <= done_in;
         rsp_overflow_ff  <= overflow_in;
         rsp_length_ff    <= len_ext[LENGTH_W-1:0];
         rsp_cmd_valid_ff <= cmd_valid_in;
         rsp_cmd_code_ff  <= cmd_code_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.read_data     = rsp_read_data_ff;
   assign rsp_chan.phase         = rsp_phase_ff;
   assign rsp_chan.frame_done    = rsp_done_ff;
   assign rsp_chan.overflow      = rsp_overflow_ff;
   assign rsp_chan.frame_length  = rsp_length_ff;
   assign rsp_chan.command_valid = rsp_cmd_valid_ff;
   assign rsp_chan.command_code  = rsp_cmd_code_ff;

endmodule

`default_nettype wire

FILE: tb/sv/frame_checker.sv
`timescale 1ns / 1ps
// Frame parser checker: predicts each response from the observed requests and compares.
module frame_checker #(
   parameter int BUF_DEPTH = ddfp_pkg::DEFAULT_BUF_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   ddfp_req_if             req,
   ddfp_rsp_if             rsp,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wr_data,
   output int              fail_count,
   output int              outstanding,
   output int              frames_seen,
   output int              overflows_seen,
   output int              commands_seen,
   output int              reads_seen
);
   import ddfp_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0]   read_data;
      logic [PHASE_W-1:0]  phase;
      logic                frame_done;
      logic                overflow;
      logic [LENGTH_W-1:0] frame_length;
      logic                command_valid;
      logic [CODE_W-1:0]   command_code;
   } status_type;

   logic [DATA_W-1:0]   start_delim;
   logic [DATA_W-1:0]   end_delim;
   logic [PHASE_W-1:0]  parse_phase;
   int                  stored;
   logic [DATA_W-1:0]   payload [BUF_DEPTH];
   logic [LENGTH_W-1:0] last_length;
   status_type          expected_status [$];
   status_type          got;
   status_type          want;

   initial begin
      fail_count = 0;
      outstanding = 0;
      frames_seen = 0;
      overflows_seen = 0;
      commands_seen = 0;
      reads_seen = 0;
   end

   task automatic report(input string msg);
      if (fail_count < 20)
         $display("MISMATCH at %0t: %s", $time, msg);
      fail_count++;
   endtask

   // Append one payload byte; on a full buffer drop the frame and return 1.
   function automatic logic store_payload(input logic [DATA_W-1:0] b);
      if (stored >= BUF_DEPTH) begin
         foreach (payload[i]) payload[i] = '0;
         stored = 0;
         parse_phase = PH_HUNT;
         return 1'b1;
      end
      payload[stored] = b;
      stored++;
      return 1'b0;
   endfunction

   task automatic predict_status(input logic op, input logic [DATA_W-1:0] b,
                                 input logic [INDEX_W-1:0] idx, output status_type s);
      s = '0;
      if (op == OP_READ) begin
         if (int'(idx) < BUF_DEPTH)
            s.read_data = payload[idx];
      end else begin
         case (parse_phase)
            PH_HUNT: begin
               if (b == start_delim)
                  parse_phase = PH_START;
            end
            PH_START: begin
               if (b == start_delim) begin
                  parse_phase = PH_PAYLOAD;
                  stored = 0;
               end else begin
                  parse_phase = PH_HUNT;
               end
            end
            PH_PAYLOAD: begin
               if (stored >= BUF_DEPTH) begin
                  s.overflow = store_payload(b);
               end else begin
                  if (b == end_delim)
                     parse_phase = PH_END;
                  void'(store_payload(b));
               end
            end
            default: begin
               if (b == end_delim) begin
                  last_length = LENGTH_W'(stored);
                  parse_phase = PH_HUNT;
                  stored = 0;
                  s.frame_done = 1'b1;
               end else begin
                  parse_phase = PH_PAYLOAD;
                  s.overflow = store_payload(b);
               end
            end
         endcase
         if (s.frame_done && payload[0] >= CHAR_CMD_FIRST && payload[0] <= CHAR_CMD_LAST) begin
            s.command_valid = 1'b1;
            s.command_code = CODE_W'(payload[0] - CHAR_CMD_FIRST);
         end
      end
      s.phase = parse_phase;
      s.frame_length = last_length;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start_delim = START_BYTE_RESET;
         end_delim = END_BYTE_RESET;
         parse_phase = PH_HUNT;
         stored = 0;
         foreach (payload[i]) payload[i] = '0;
         last_length = '0;
         expected_status.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_START_BYTE)
               start_delim = csr_wr_data;
            else
               end_delim = csr_wr_data;
         end
         // Compare before predicting so a stray response cannot match a fresh entry.
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.read_data, rsp.phase, rsp.frame_done, rsp.overflow,
                    rsp.frame_length, rsp.command_valid, rsp.command_code};
            if (expected_status.size() == 0) begin
               report("response transfer with nothing outstanding");
            end else begin
               want = expected_status.pop_front();
               if (got.read_data !== want.read_data)
                  report($sformatf("read_data got %0h want %0h", got.read_data, want.read_data));
               if (got.phase !== want.phase)
                  report($sformatf("phase got %0d want %0d", got.phase, want.phase));
               if (got.frame_done !== want.frame_done)
                  report($sformatf("frame_done got %0b want %0b", got.frame_done,
                                   want.frame_done));
               if (got.overflow !== want.overflow)
                  report($sformatf("overflow got %0b want %0b", got.overflow, want.overflow));
               if (got.frame_length !== want.frame_length)
                  report($sformatf("frame_length got %0d want %0d", got.frame_length,
                                   want.frame_length));
               if (got.command_valid !== want.command_valid)
                  report($sformatf("command_valid got %0b want %0b", got.command_valid,
                                   want.command_valid));
               if (got.command_code !== want.command_code)
                  report($sformatf("command_code got %0d want %0d", got.command_code,
                                   want.command_code));
            end
            frames_seen += (got.frame_done === 1'b1);
            overflows_seen += (got.overflow === 1'b1);
            commands_seen += (got.command_valid === 1'b1);
         end
         if (req.valid && req.ready) begin
            predict_status(req.op, req.rx_byte, req.read_index, want);
            expected_status.push_back(want);
            reads_seen += (req.op == OP_READ);
         end
      end
      outstanding <= expected_status.size();
   end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the frame parser testbench: clock, reset, stimulus, stalls and verdict.
module testbench;
   import ddfp_pkg::*;

   localparam int ITEMS_PER_PHASE = 380;
   localparam logic [DATA_W-1:0] CHAR_ZERO = "0";
   localparam logic [DATA_W-1:0] CHAR_NINE = "9";

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic              csr_index = CSR_START_BYTE;
   logic [DATA_W-1:0] csr_wr_data = '0;

   int fail_count, outstanding, frames_seen, overflows_seen, commands_seen, reads_seen;
   int burst_left = 0;
   int useful_items = 0;
   int ready_left = 0;
   int ready_mode = 0;
   logic [DATA_W-1:0] cur_start = START_BYTE_RESET;
   logic [DATA_W-1:0] cur_end = END_BYTE_RESET;

   ddfp_req_if req_chan ();
   ddfp_rsp_if rsp_chan ();

   always #2 clock = ~clock;

   double_delimiter_frame_parser u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   frame_checker u_frame_chk (
      .clock          (clock),
      .reset          (reset),
      .req            (req_chan),
      .rsp            (rsp_chan),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .fail_count     (fail_count),
      .outstanding    (outstanding),
      .frames_seen    (frames_seen),
      .overflows_seen (overflows_seen),
      .commands_seen  (commands_seen),
      .reads_seen     (reads_seen)
   );

   // Receiver: switch at random between four stall patterns.
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_left = $urandom_range(10, 60);
      end
      ready_left--;
      case (ready_mode)
         0: rsp_chan.ready <= 1'b1;
         1: rsp_chan.ready <= 1'($urandom_range(0, 1));
         2: rsp_chan.ready <= ($urandom_range(0, 7) != 0);
         default: rsp_chan.ready <= (ready_left % 8 == 0);
      endcase
   end

   task automatic send(input logic op, input logic [DATA_W-1:0] b,
                       input logic [INDEX_W-1:0] idx);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_chan.valid <= 1'b1;
      req_chan.op <= op;
      req_chan.rx_byte <= b;
      req_chan.read_index <= idx;
      do @(posedge clock); while (!req_chan.ready);
      useful_items++;
   endtask

   task automatic rx(input logic [DATA_W-1:0] b);
      send(OP_RECEIVE, b, INDEX_W'($urandom_range(0, 31)));
   endtask

   task automatic rd(input logic [INDEX_W-1:0] idx);
      send(OP_READ, DATA_W'($urandom_range(0, 255)), idx);
   endtask

   // Hold the sender until every response is back, then let the pipeline settle.
   task automatic drain();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_delimiters(input logic [DATA_W-1:0] s, input logic [DATA_W-1:0] e);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_START_BYTE;
      csr_wr_data <= s;
      @(posedge clock);
      csr_index <= CSR_END_BYTE;
      csr_wr_data <= e;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_start = s;
      cur_end = e;
   endtask

   function automatic logic [DATA_W-1:0] payload_byte(input int pos);
      int r;
      r = $urandom_range(0, 99);
      if (pos == 0 && r < 60)
         return DATA_W'($urandom_range(CHAR_ZERO, CHAR_NINE));
      if (r < 15)
         return cur_end;
      if (r < 20)
         return cur_start;
      if (r < 30)
         return DATA_W'($urandom_range(CHAR_ZERO, CHAR_NINE));
      return DATA_W'($urandom_range(0, 255));
   endfunction

   task automatic random_sequence();
      int r, len;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         // well-formed frame, sometimes long enough to fill or overrun the buffer
         rx(cur_start);
         rx(cur_start);
         if ($urandom_range(0, 9) == 0)
            len = $urandom_range(DEFAULT_BUF_DEPTH - 3, DEFAULT_BUF_DEPTH + 3);
         else
            len = $urandom_range(0, 8);
         for (int i = 0; i < len; i++) rx(payload_byte(i));
         rx(cur_end);
         rx(cur_end);
         repeat ($urandom_range(0, 3))
            rd(INDEX_W'($urandom_range(0, (len > 0 && len < 32) ? len : 31)));
      end else if (r < 65) begin
         rx(cur_start);
         rx(DATA_W'($urandom_range(0, 255)));
      end else if (r < 75) begin
         // truncated frame: the next sequence lands in its payload
         rx(cur_start);
         rx(cur_start);
         repeat ($urandom_range(0, 4)) rx(payload_byte(1));
      end else if (r < 85) begin
         repeat ($urandom_range(1, 3)) rd(INDEX_W'($urandom_range(0, 31)));
      end else begin
         repeat ($urandom_range(1, 4)) send(OP_RECEIVE, DATA_W'($urandom_range(0, 255)),
                                            INDEX_W'($urandom_range(0, 31)));
      end
   endtask

   task automatic random_phase(input logic [DATA_W-1:0] s, input logic [DATA_W-1:0] e);
      int target;
      set_delimiters(s, e);
      target = useful_items + ITEMS_PER_PHASE;
      while (useful_items < target) random_sequence();
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.op = OP_RECEIVE;
      req_chan.rx_byte = '0;
      req_chan.read_index = '0;
      rsp_chan.ready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: reads of a clean buffer, ignored bytes, a lone start,
      // a single end kept as data, byte extremes and non-command first bytes.
      rd(0);
      rd(31);
      rx("x");
      rx("a");
      rx("x");
      rx("a");
      rx("a");
      rx("3");
      rx("b");
      rx("q");
      rx("b");
      rx("b");
      rd(1);
      rx("a");
      rx("a");
      rx(8'hFF);
      rx(8'h00);
      rx("b");
      rx("b");
      rd(0);
      rx("a");
      rx("a");
      rx("7");
      rx("b");
      rx("b");

      random_phase(START_BYTE_RESET, END_BYTE_RESET);
      random_phase(8'h00, 8'hFF);
      random_phase(8'hFF, 8'h00);
      random_phase(8'h7E, 8'h7E);
      random_phase(DATA_W'($urandom_range(0, 255)), DATA_W'($urandom_range(0, 255)));

      drain();
      $display("Covered %0d requests (%0d reads) over five delimiter settings.",
               useful_items, reads_seen);
      $display("Saw %0d completed frames, %0d with a command, %0d buffer overruns.",
               frames_seen, commands_seen, overflows_seen);
      if (fail_count == 0 && outstanding == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
